// ----- design/dxt_block_decoder_unit_defines.svh -----
// ----------------------------------------------------------------------------
// dxt_block_decoder_unit_defines.svh
// Assertion macros shared by the checker of the block decoder.
// ----------------------------------------------------------------------------
`ifndef DXT_BLOCK_DECODER_UNIT_DEFINES_SVH
`define DXT_BLOCK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is active.
`define DXT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is active.
`define DXT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication checked at every edge, reset included.
`define DXT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/dxt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_pkg
// Types, codes and arithmetic helpers of the S3TC block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int DIM_W      = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 15'd16384;

    // Scale constants: 255 times a rounded-up reciprocal of 31 or 63, shift 22.
    localparam logic [31:0] K_EXP5 = 32'd34501755;
    localparam logic [31:0] K_EXP6 = 32'd16977135;

    // One decoded block as handed from the front to the back.
    typedef struct packed {
        logic [3:0][2:0][7:0] pal;      // entry, channel (r g b)
        logic                 transp3;  // DXT1 entry 3 is transparent black
        logic [7:0][7:0]      apal;
        logic [31:0]          cidx;
        logic [63:0]          ahalf;
        logic [1:0]           fmt;
        logic [11:0]          bcol;
        logic [11:0]          brow;
        logic [15:0]          mask;     // cells inside the image
    } blk_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [31:0] p;
        p = 32'(v) * K_EXP5;
        return p[29:22];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [31:0] p;
        p = 32'(v) * K_EXP6;
        return p[29:22];
    endfunction

    // Floor division by 3 for values up to 765.
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd2731;
        return p[20:13];
    endfunction

    // Floor division by 5 for values up to 1275.
    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd1639;
        return p[20:13];
    endfunction

    // Floor division by 7 for values up to 1785.
    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [21:0] p;
        p = 22'(v) * 22'd2341;
        return p[21:14];
    endfunction

endpackage

// ----- design/dxt_block_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_block_decoder_unit
// S3TC DXT1/DXT3/DXT5 block decoder, one RGBA pixel per visible cell.
// ----------------------------------------------------------------------------
// Blocks enter through push/full with both 64-bit halves and the block
// position. Pixels leave through empty/pop, row-major within the block; the
// last pixel emitted for a block carries last_pixel. Format and image size
// are written through cfg_valid/cfg_ready (always ready), by the user only
// while the block is idle; the block does not enforce this. Writes to unused
// indexes are ignored. A block passes the front stage, the queue and the
// walker's block register before its first pixel reaches the output slot.
// The pixel walker emits one pixel per cycle while the receiver pops;
// blocks with no visible cell or format code 3 are dropped by the front.
// The front takes a new block every cycle until the block queue is full.
// Reset clears the front stage, queue and output slot; format returns to
// DXT1 and width and height to 16384. When the receiver stops popping, the
// pixel holds, the walker stops, and the queue then fills and raises full.
// ----------------------------------------------------------------------------
module dxt_block_decoder_unit #(
    parameter int QUEUE_DEPTH = dxt_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [63:0]                     color_half,
    input  logic [63:0]                     alpha_half,
    input  logic [11:0]                     block_col,
    input  logic [11:0]                     block_row,
    output logic                            empty,
    input  logic                            pop,
    output logic [13:0]                     pixel_x,
    output logic [13:0]                     pixel_y,
    output logic [7:0]                      red,
    output logic [7:0]                      green,
    output logic [7:0]                      blue,
    output logic [7:0]                      alpha,
    output logic                            last_pixel,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dxt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dxt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [1:0]                format_reg;
    logic [dxt_pkg::DIM_W-1:0] width_reg;
    logic [dxt_pkg::DIM_W-1:0] height_reg;

    logic          q_wr;
    logic          q_rd;
    logic          q_full;
    logic          q_empty;
    dxt_pkg::blk_t q_wdata;
    dxt_pkg::blk_t q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= dxt_pkg::FMT_DXT1;
            width_reg  <= dxt_pkg::DIM_RESET;
            height_reg <= dxt_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dxt_pkg::CFG_FORMAT: format_reg <= cfg_data[1:0];
                dxt_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                dxt_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dxt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .color_half   (color_half),
        .alpha_half   (alpha_half),
        .block_col    (block_col),
        .block_row    (block_row),
        .block_format (format_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_data       (q_wdata)
    );

    dxt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    dxt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last_pixel (last_pixel)
    );

endmodule

// ----- design/dxt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_front
// Accepts blocks, expands endpoints, builds palettes and the inside mask.
// ----------------------------------------------------------------------------
module dxt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [63:0]                   color_half,
    input  logic [63:0]                   alpha_half,
    input  logic [11:0]                   block_col,
    input  logic [11:0]                   block_row,
    input  logic [1:0]                    block_format,
    input  logic [dxt_pkg::DIM_W-1:0]     image_width,
    input  logic [dxt_pkg::DIM_W-1:0]     image_height,
    input  logic                          q_full,
    output logic                          q_wr,
    output dxt_pkg::blk_t                 q_data
);

    typedef struct packed {
        logic [63:0]          color;
        logic [63:0]          ahalf;
        logic [11:0]          bcol;
        logic [11:0]          brow;
        logic [2:0][7:0]      e0;
        logic [2:0][7:0]      e1;
        logic [2:0][9:0]      sum2;
        logic [2:0][9:0]      sum3;
        logic [2:0][8:0]      sumh;
        logic [5:0][10:0]     asum7;
        logic [3:0][10:0]     asum5;
    } s1_t;

    logic s1_valid_reg;
    logic s1_valid_next;
    s1_t  s1_reg;
    s1_t  s1_next;

    logic        accept;
    logic        drain;
    logic        keep;
    logic        three;
    logic        a_gt;
    logic [3:0]  row_ok;
    logic [3:0]  col_ok;
    logic [15:0] mask;

    // Stage 1: endpoint expansion and weighted sums.
    always_comb
    begin
        s1_next       = '0;
        s1_next.color = color_half;
        s1_next.ahalf = alpha_half;
        s1_next.bcol  = block_col;
        s1_next.brow  = block_row;
        s1_next.e0[0] = dxt_pkg::expand5(color_half[15:11]);
        s1_next.e0[1] = dxt_pkg::expand6(color_half[10:5]);
        s1_next.e0[2] = dxt_pkg::expand5(color_half[4:0]);
        s1_next.e1[0] = dxt_pkg::expand5(color_half[31:27]);
        s1_next.e1[1] = dxt_pkg::expand6(color_half[26:21]);
        s1_next.e1[2] = dxt_pkg::expand5(color_half[20:16]);
        for (int ch = 0; ch < 3; ch++)
        begin
            s1_next.sum2[ch] = 10'({s1_next.e0[ch], 1'b0}) + 10'(s1_next.e1[ch]);
            s1_next.sum3[ch] = 10'(s1_next.e0[ch]) + 10'({s1_next.e1[ch], 1'b0});
            s1_next.sumh[ch] = 9'(s1_next.e0[ch]) + 9'(s1_next.e1[ch]);
        end
        for (int k = 1; k <= 6; k++)
        begin
            s1_next.asum7[k-1] = 11'(7 - k) * 11'(alpha_half[7:0])
                               + 11'(k) * 11'(alpha_half[15:8]);
        end
        for (int k = 1; k <= 4; k++)
        begin
            s1_next.asum5[k-1] = 11'(5 - k) * 11'(alpha_half[7:0])
                               + 11'(k) * 11'(alpha_half[15:8]);
        end
    end

    // Stage 2: divides, mask and classification, written into the queue.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            row_ok[r] = {1'b0, s1_reg.brow, 2'(r)} < image_height;
            col_ok[r] = {1'b0, s1_reg.bcol, 2'(r)} < image_width;
        end
        for (int i = 0; i < 16; i++)
        begin
            mask[i] = row_ok[i / 4] & col_ok[i % 4];
        end

        three = (block_format != dxt_pkg::FMT_DXT1)
              || (s1_reg.color[15:0] > s1_reg.color[31:16]);
        a_gt  = s1_reg.ahalf[7:0] > s1_reg.ahalf[15:8];

        q_data        = '0;
        q_data.pal[0] = s1_reg.e0;
        q_data.pal[1] = s1_reg.e1;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (three)
            begin
                q_data.pal[2][ch] = dxt_pkg::div3(s1_reg.sum2[ch]);
                q_data.pal[3][ch] = dxt_pkg::div3(s1_reg.sum3[ch]);
            end
            else
            begin
                q_data.pal[2][ch] = s1_reg.sumh[ch][8:1];
                q_data.pal[3][ch] = 8'd0;
            end
        end
        q_data.transp3 = !three;

        q_data.apal[0] = s1_reg.ahalf[7:0];
        q_data.apal[1] = s1_reg.ahalf[15:8];
        if (a_gt)
        begin
            for (int k = 0; k < 6; k++)
            begin
                q_data.apal[k+2] = dxt_pkg::div7(s1_reg.asum7[k]);
            end
        end
        else
        begin
            for (int k = 0; k < 4; k++)
            begin
                q_data.apal[k+2] = dxt_pkg::div5(s1_reg.asum5[k]);
            end
            q_data.apal[6] = 8'd0;
            q_data.apal[7] = 8'd255;
        end

        q_data.cidx  = s1_reg.color[63:32];
        q_data.ahalf = s1_reg.ahalf;
        q_data.fmt   = block_format;
        q_data.bcol  = s1_reg.bcol;
        q_data.brow  = s1_reg.brow;
        q_data.mask  = mask;
    end

    // Drop blocks with no visible cell or an undefined format.
    assign keep   = (block_format != dxt_pkg::FMT_NONE) && (mask != 16'd0);
    assign drain  = s1_valid_reg && (!keep || !q_full);
    assign q_wr   = s1_valid_reg && keep && !q_full;
    assign full   = s1_valid_reg && !drain;
    assign accept = push && !full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (drain)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

endmodule

// ----- design/dxt_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_queue
// Short queue of decoded blocks between the front and the back.
// ----------------------------------------------------------------------------
module dxt_queue #(
    parameter int DEPTH = dxt_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  dxt_pkg::blk_t wdata,
    input  logic          rd,
    output dxt_pkg::blk_t rdata,
    output logic          full,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dxt_pkg::blk_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- design/dxt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_back
// Walks the visible cells of a block and emits one pixel per cycle while the receiver pops.
// ----------------------------------------------------------------------------
module dxt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  dxt_pkg::blk_t q_data,
    output logic          q_rd,
    output logic          empty,
    input  logic          pop,
    output logic [13:0]   pixel_x,
    output logic [13:0]   pixel_y,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue,
    output logic [7:0]    alpha,
    output logic          last_pixel
);

    typedef struct packed {
        logic [13:0] x;
        logic [13:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        last;
    } pix_t;

    dxt_pkg::blk_t cur_reg;
    logic [15:0]   mask_reg;
    logic [15:0]   mask_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    pix_t          pix_reg;
    pix_t          pix_next;

    logic [15:0] lsb;
    logic [15:0] rest;
    logic [3:0]  cell_idx;
    logic [1:0]  ci;
    logic [3:0]  nib;
    logic [2:0]  ai;
    logic        advance;
    logic        load;

    assign lsb  = mask_reg & (~mask_reg + 16'd1);
    assign rest = mask_reg & ~lsb;

    always_comb
    begin
        cell_idx = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (lsb[i])
            begin
                cell_idx = cell_idx | 4'(i);
            end
        end
    end

    assign ci  = cur_reg.cidx[{cell_idx, 1'b0} +: 2];
    assign nib = cur_reg.ahalf[{cell_idx, 2'b00} +: 4];
    assign ai  = cur_reg.ahalf[6'd16 + 6'({cell_idx, 1'b0}) + 6'(cell_idx) +: 3];

    always_comb
    begin
        pix_next.x    = {cur_reg.bcol, cell_idx[1:0]};
        pix_next.y    = {cur_reg.brow, cell_idx[3:2]};
        pix_next.r    = cur_reg.pal[ci][0];
        pix_next.g    = cur_reg.pal[ci][1];
        pix_next.b    = cur_reg.pal[ci][2];
        pix_next.last = rest == 16'd0;
        case (cur_reg.fmt)
            dxt_pkg::FMT_DXT3: pix_next.a = {nib, nib};
            dxt_pkg::FMT_DXT5: pix_next.a = cur_reg.apal[ai];
            default:           pix_next.a = (cur_reg.transp3 && ci == 2'd3) ? 8'd0 : 8'd255;
        endcase
    end

    // Advance when the output slot frees; fetch the next block as this one ends or while none is held.
    assign advance = (mask_reg != 16'd0) && (!out_valid_reg || pop);
    assign load    = !q_empty && ((mask_reg == 16'd0) || (advance && rest == 16'd0));
    assign q_rd    = load;

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = q_data.mask;
        end
        else if (advance)
        begin
            mask_next = rest;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_data;
        end
        if (advance)
        begin
            pix_reg <= pix_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign pixel_x    = pix_reg.x;
    assign pixel_y    = pix_reg.y;
    assign red        = pix_reg.r;
    assign green      = pix_reg.g;
    assign blue       = pix_reg.b;
    assign alpha      = pix_reg.a;
    assign last_pixel = pix_reg.last;

endmodule

// ----- design/dxt_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_chk
// Port-level checks of the block decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dxt_block_decoder_unit_defines.svh"

module dxt_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [13:0] pixel_x,
    input logic [13:0] pixel_y,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue,
    input logic [7:0]  alpha,
    input logic        last_pixel
);

    logic [60:0] pix_word;
    logic [23:0] bpos;
    logic [3:0]  cpos;
    logic        stalled;
    logic        mid_pop;

    assign pix_word = {pixel_x, pixel_y, red, green, blue, alpha, last_pixel};
    assign bpos     = {pixel_y[13:2], pixel_x[13:2]};
    assign cpos     = {pixel_y[1:0], pixel_x[1:0]};
    assign stalled  = !empty && !pop;
    assign mid_pop  = pop && !empty && !last_pixel;

    // Both channels idle while reset is held and was already held at the last sampled edge.
    `DXT_ASSERT_ALWAYS(a_reset_idle, !rst_n && $past(!rst_n), empty && !full, "not idle in reset")

    // A shown pixel holds until popped.
    `DXT_ASSERT_NEXT(a_pixel_hold, stalled, !empty && $stable(pix_word), "pixel not held")

    // Within a block, the next pixel follows at once, same block, later cell.
    `DXT_ASSERT_NEXT(a_block_order, mid_pop, !empty && $stable(bpos) && cpos > $past(cpos), "bad order")

    // A shown pixel carries a known last flag.
    `DXT_ASSERT_NOW(a_last_known, !empty, !$isunknown(last_pixel), "last flag unknown")

endmodule

bind dxt_block_decoder_unit dxt_chk u_chk (.*);

// ----- verif/dxt_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dxt_pixel_checker
// Watches the block, config and pixel channels of the S3TC block decoder.
// ----------------------------------------------------------------------------
// Tracks format and image size from the config channel, decodes every
// accepted block into the pixels it must produce and compares each popped
// pixel field by field with the oldest one still owed. The failure count and
// the number of owed pixels go back to the testbench top.
// ----------------------------------------------------------------------------
module dxt_pixel_checker
    import dxt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic [63:0]           color_half,
    input  logic [63:0]           alpha_half,
    input  logic [11:0]           block_col,
    input  logic [11:0]           block_row,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [13:0]           pixel_x,
    input  logic [13:0]           pixel_y,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            alpha,
    input  logic                  last_pixel,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    pending
);

    typedef struct {
        logic [13:0] x;
        logic [13:0] y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        last;
    } pixel_t;

    pixel_t           owed_pixels[$];
    logic [1:0]       fmt_reg    = FMT_DXT1;
    logic [DIM_W-1:0] width_reg  = DIM_RESET;
    logic [DIM_W-1:0] height_reg = DIM_RESET;

    function automatic int widen(input int v, input int top);
        return v * 255 / top;
    endfunction

    task automatic decode_block(input logic [63:0] ch, input logic [63:0] ah,
                                input logic [11:0] col, input logic [11:0] row);
        logic [15:0] c0;
        logic [15:0] c1;
        logic        four_color;
        int          rgb [4][3];
        int          apal [8];
        int          xp;
        int          yp;
        int          ci;
        int          k;
        int          n;
        pixel_t      px [16];
        n = 0;
        if (fmt_reg == FMT_NONE)
            return;
        c0 = ch[15:0];
        c1 = ch[31:16];
        rgb[0][0] = widen(c0[15:11], 31);
        rgb[0][1] = widen(c0[10:5], 63);
        rgb[0][2] = widen(c0[4:0], 31);
        rgb[1][0] = widen(c1[15:11], 31);
        rgb[1][1] = widen(c1[10:5], 63);
        rgb[1][2] = widen(c1[4:0], 31);
        four_color = (c0 > c1) || (fmt_reg != FMT_DXT1);
        for (k = 0; k < 3; k++) begin
            if (four_color) begin
                rgb[2][k] = (2 * rgb[0][k] + rgb[1][k]) / 3;
                rgb[3][k] = (rgb[0][k] + 2 * rgb[1][k]) / 3;
            end
            else begin
                // three-color mode: midpoint, then transparent black
                rgb[2][k] = (rgb[0][k] + rgb[1][k]) / 2;
                rgb[3][k] = 0;
            end
        end
        apal[0] = ah[7:0];
        apal[1] = ah[15:8];
        if (apal[0] > apal[1]) begin
            for (k = 1; k <= 6; k++)
                apal[k+1] = ((7 - k) * apal[0] + k * apal[1]) / 7;
        end
        else begin
            for (k = 1; k <= 4; k++)
                apal[k+1] = ((5 - k) * apal[0] + k * apal[1]) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end
        for (k = 0; k < 16; k++) begin
            xp = int'(col) * 4 + k % 4;
            yp = int'(row) * 4 + k / 4;
            if (xp >= int'(width_reg) || yp >= int'(height_reg))
                continue;
            ci = int'(ch[32 + 2 * k +: 2]);
            px[n].x    = 14'(xp);
            px[n].y    = 14'(yp);
            px[n].r    = 8'(rgb[ci][0]);
            px[n].g    = 8'(rgb[ci][1]);
            px[n].b    = 8'(rgb[ci][2]);
            px[n].last = 1'b0;
            case (fmt_reg)
                FMT_DXT3: px[n].a = 8'(int'(ah[4 * k +: 4]) * 17);
                FMT_DXT5: px[n].a = 8'(apal[ah[16 + 3 * k +: 3]]);
                default:  px[n].a = (!four_color && ci == 3) ? 8'd0 : 8'd255;
            endcase
            n++;
        end
        if (n > 0)
            px[n-1].last = 1'b1;
        for (k = 0; k < n; k++)
            owed_pixels.push_back(px[k]);
    endtask

    always @(posedge clk or negedge rst_n) begin
        pixel_t e;
        if (!rst_n) begin
            fmt_reg    = FMT_DXT1;
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            owed_pixels.delete();
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FORMAT: fmt_reg    = cfg_data[1:0];
                    CFG_WIDTH:  width_reg  = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (owed_pixels.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%t pixel with no block owed: x=%0d y=%0d", $realtime,
                                 pixel_x, pixel_y);
                end
                else begin
                    e = owed_pixels.pop_front();
                    if (pixel_x !== e.x || pixel_y !== e.y || red !== e.r ||
                        green !== e.g || blue !== e.b || alpha !== e.a ||
                        last_pixel !== e.last) begin
                        failures++;
                        if (failures <= 10)
                            $display({"%t pixel mismatch: expected x=%0d y=%0d ",
                                      "rgba=%h_%h_%h_%h last=%b, got x=%0d y=%0d ",
                                      "rgba=%h_%h_%h_%h last=%b"},
                                     $realtime, e.x, e.y, e.r, e.g, e.b, e.a, e.last,
                                     pixel_x, pixel_y, red, green, blue, alpha,
                                     last_pixel);
                    end
                end
            end
            if (push && !full)
                decode_block(color_half, alpha_half, block_col, block_row);
            pending <= owed_pixels.size();
        end
    end

endmodule

// ----- verif/tb_dxt_block_decoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dxt_block_decoder_unit
// Stimulus and verdict for the S3TC block decoder.
// ----------------------------------------------------------------------------
// Runs directed blocks over every format, palette mode and clipping case,
// then random phases with fresh format and image size, random gaps on both
// sides, one long output stall and one stretch without gaps. Checking is
// done by dxt_pixel_checker next to the block.
// ----------------------------------------------------------------------------
module tb_dxt_block_decoder_unit;
    import dxt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int IDLE_PCT      = 23;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASES        = 10;
    localparam int PHASE_BLOCKS  = 24;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [63:0]           color_half;
    logic [63:0]           alpha_half;
    logic [11:0]           block_col;
    logic [11:0]           block_row;
    logic                  empty;
    logic                  pop;
    logic [13:0]           pixel_x;
    logic [13:0]           pixel_y;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [7:0]            alpha;
    logic                  last_pixel;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    pending;
    logic                  hold_output;
    logic                  tx_calm;
    logic                  rx_calm;

    dxt_block_decoder_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .color_half(color_half), .alpha_half(alpha_half),
        .block_col(block_col), .block_row(block_row),
        .empty(empty), .pop(pop), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .last_pixel(last_pixel), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    dxt_pixel_checker chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .color_half(color_half), .alpha_half(alpha_half),
        .block_col(block_col), .block_row(block_row),
        .empty(empty), .pop(pop), .pixel_x(pixel_x), .pixel_y(pixel_y),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .last_pixel(last_pixel), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] rand_color();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            v[31:16] = v[15:0];
        return v;
    endfunction

    function automatic logic [63:0] rand_alpha();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(7) == 0)
            v[15:8] = v[7:0];
        return v;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(3))
            0:       return DIM_W'($urandom_range(64, 1));
            1:       return DIM_W'($urandom_range(32767, 1));
            2:       return DIM_RESET;
            default: return DIM_W'($urandom_range(16384, 16000));
        endcase
    endfunction

    // Pick a block up to one block past the image edge, one time in ten anywhere, so clipping shows up.
    function automatic logic [11:0] pick_pos(input logic [DIM_W-1:0] dim);
        int lim;
        lim = (int'(dim) + 3) / 4;
        if (lim > 4095 || $urandom_range(9) == 0)
            lim = 4095;
        return 12'($urandom_range(lim));
    endfunction

    task automatic push_block(input logic [63:0] ch, input logic [63:0] ah,
                              input logic [11:0] col, input logic [11:0] row);
        while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        color_half <= ch;
        alpha_half <= ah;
        block_col  <= col;
        block_row  <= row;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Drop push, drain every owed pixel, then give the front time to go idle.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [1:0] fmt, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h, input bit poke_unused);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int                    n;
        int                    i;
        idx[0] = CFG_FORMAT;  val[0] = {13'($urandom), fmt};
        idx[1] = CFG_WIDTH;   val[1] = w;
        idx[2] = CFG_HEIGHT;  val[2] = h;
        idx[3] = CFG_UNUSED;  val[3] = CFG_DATA_W'($urandom);
        n = poke_unused ? 4 : 3;
        for (i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Output side: random pop gaps, plus one long stall on request.
    initial begin
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_output) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_output = 1'b0;
            end
            else begin
                pop <= rx_calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        logic [1:0]       f;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               ph;
        rst_n       = 1'b0;
        push        = 1'b0;
        color_half  = '0;
        alpha_half  = '0;
        block_col   = '0;
        block_row   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_FORMAT;
        cfg_data    = '0;
        hold_output = 1'b0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // DXT1 at reset size: four-color, three-color, equal endpoints, corners
        push_block(64'hE4E4E4E4_0000FFFF, rand_alpha(), 12'd0, 12'd0);
        push_block(64'hE4E4E4E4_FFFF0000, rand_alpha(), 12'd1, 12'd0);
        push_block(64'hE4E4E4E4_84108410, rand_alpha(), 12'd0, 12'd1);
        push_block(64'hE4E4E4E4_F80007E0, rand_alpha(), 12'd7, 12'd9);
        push_block('1, '1, 12'd4095, 12'd4095);
        push_block('0, '0, 12'd0, 12'd4095);

        // DXT3: every nibble value, all-ones and all-zero alpha
        settle();
        write_regs(FMT_DXT3, DIM_RESET, DIM_RESET, 1'b0);
        push_block(64'hE4E4E4E4_F81F07E0, 64'hFEDCBA98_76543210, 12'd1, 12'd2);
        push_block(rand_color(), '1, 12'd4095, 12'd0);
        push_block(rand_color(), '0, 12'd3, 12'd3);

        // DXT5: both alpha palette modes, every index value
        settle();
        write_regs(FMT_DXT5, DIM_RESET, DIM_RESET, 1'b0);
        push_block(rand_color(), {48'hFAC688_FAC688, 8'h10, 8'hF0}, 12'd2, 12'd5);
        push_block(rand_color(), {48'hFAC688_FAC688, 8'hF0, 8'h10}, 12'd5, 12'd2);
        push_block(rand_color(), {48'hFAC688_FAC688, 8'h80, 8'h80}, 12'd9, 12'd9);
        push_block(rand_color(), {48'hFAC688_FAC688, 8'h00, 8'hFF}, 12'd0, 12'd0);

        // format code 3 yields nothing; also hit the unused register index
        settle();
        write_regs(FMT_NONE, DIM_RESET, DIM_RESET, 1'b1);
        push_block(rand_color(), rand_alpha(), 12'd5, 12'd5);

        // small image: partial block, block fully outside, full block
        settle();
        write_regs(FMT_DXT1, 15'd6, 15'd5, 1'b0);
        push_block(rand_color(), rand_alpha(), 12'd1, 12'd1);
        push_block(rand_color(), rand_alpha(), 12'd2, 12'd0);
        push_block(rand_color(), rand_alpha(), 12'd0, 12'd0);

        // zero-size image, then a single-pixel image
        settle();
        write_regs(FMT_DXT5, 15'd0, 15'd0, 1'b0);
        push_block(rand_color(), rand_alpha(), 12'd0, 12'd0);
        settle();
        write_regs(FMT_DXT3, 15'd1, 15'd1, 1'b0);
        push_block(rand_color(), rand_alpha(), 12'd0, 12'd0);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin f = FMT_DXT5; w = DIM_RESET; h = DIM_RESET; end
                1: begin f = FMT_DXT1; w = 15'h7FFF;  h = 15'h7FFF;  end
                2: begin f = FMT_DXT3; w = 15'd1;     h = DIM_RESET; end
                3: begin f = FMT_DXT1; w = DIM_RESET; h = 15'd1;     end
                default: begin
                    f = 2'($urandom_range(2));
                    w = pick_dim();
                    h = pick_dim();
                end
            endcase
            settle();
            write_regs(f, w, h, $urandom_range(3) == 0);
            tx_calm = (ph == 1);
            rx_calm = (ph == 1);
            // stall the output long enough for the block to fill and raise full
            if (ph == 0)
                hold_output = 1'b1;
            repeat (PHASE_BLOCKS)
                push_block(rand_color(), rand_alpha(), pick_pos(w), pick_pos(h));
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        settle();
        if (failures == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
